// File: sv/trc_pkg.sv
// Shared types and constants of the tristate remote code receiver.
// No dependencies; every other file refers to this package by scoped names.
package trc_pkg;

  localparam int FRAME_SAMPLES = 25;
  localparam int DIGITS        = 12;
  localparam int ADDR_DIGITS   = DIGITS / 2;
  localparam int DIGIT_W       = 2;
  localparam int FIELD_W       = 12;
  localparam int CNT_W         = $clog2(FRAME_SAMPLES + 1);
  localparam int TICK_W        = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [TICK_W-1:0]  SAMPLE_DELAY_RST   = 16'd1392;
  localparam logic [TICK_W-1:0]  BIT_TIMEOUT_RST    = 16'd1536;
  localparam logic [FIELD_W-1:0] PRESET_ADDRESS_RST = 12'd1365;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_ADDRESS = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PAIR = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    status_t              frame_status;
    logic [FIELD_W-1:0]   data_digits;
    logic [FIELD_W-1:0]   address_digits;
  } result_t;

endpackage

// File: sv/tristate_remote_code_receiver.sv
// Tristate remote code receiver: one line level per beat, one result per frame.
// Each result is registered in the output slot, or the skid slot while that is held.
// Throughput: one beat per cycle; input stalls only while both result slots are full.
// Reset: synchronous active-low rst_n clears sample state, timer and result slots,
// and loads the register defaults. Depends on trc_pkg, trc_decode, trc_out_skid.
module tristate_remote_code_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_line_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_frame_status,
  output logic [trc_pkg::FIELD_W-1:0]       out_data_digits,
  output logic [trc_pkg::FIELD_W-1:0]       out_address_digits,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trc_pkg::TICK_W-1:0]        cfg_data
);

  logic [trc_pkg::TICK_W-1:0]        sample_delay_r;
  logic [trc_pkg::TICK_W-1:0]        bit_timeout_r;
  logic [trc_pkg::FIELD_W-1:0]       preset_address_r;

  logic [trc_pkg::FRAME_SAMPLES-1:0] store_r, store_nxt;
  logic [trc_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                              pend_r, pend_nxt;
  logic [trc_pkg::TICK_W-1:0]        cd_r, cd_nxt;
  logic                              run_r, run_nxt;
  logic                              emit;
  logic                              in_acc;
  logic                              buf_full;
  trc_pkg::result_t                  frame_result;
  trc_pkg::result_t                  out_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_delay_r   <= trc_pkg::SAMPLE_DELAY_RST;
      bit_timeout_r    <= trc_pkg::BIT_TIMEOUT_RST;
      preset_address_r <= trc_pkg::PRESET_ADDRESS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == trc_pkg::REG_SAMPLE_DELAY) sample_delay_r <= cfg_data;
      if (cfg_index == trc_pkg::REG_BIT_TIMEOUT) bit_timeout_r <= cfg_data;
      if (cfg_index == trc_pkg::REG_PRESET_ADDRESS) begin
        preset_address_r <= cfg_data[trc_pkg::FIELD_W-1:0];
      end
    end
  end

  always_comb begin
    store_nxt = store_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    cd_nxt    = cd_r;
    run_nxt   = run_r;
    emit      = 1'b0;

    if (run_r) begin
      if (cd_r != '0) cd_nxt = cd_r - trc_pkg::TICK_W'(1);
      if (cd_nxt == '0) begin
        if (pend_r) begin
          // take the sample, then arm the bit timeout
          pend_nxt = 1'b0;
          if (cnt_r < trc_pkg::CNT_W'(trc_pkg::FRAME_SAMPLES)) begin
            for (int i = 0; i < trc_pkg::FRAME_SAMPLES; i++) begin
              if (cnt_r == trc_pkg::CNT_W'(i)) store_nxt[i] = in_line_level;
            end
            cnt_nxt = cnt_r + trc_pkg::CNT_W'(1);
          end
          cd_nxt  = (bit_timeout_r == '0) ? trc_pkg::TICK_W'(1) : bit_timeout_r;
          run_nxt = 1'b1;
        end else begin
          // timeout with no new low: drop the partial frame
          cnt_nxt = '0;
          run_nxt = 1'b0;
        end
      end
    end

    if (!in_line_level && !pend_nxt) begin
      cd_nxt   = (sample_delay_r == '0) ? trc_pkg::TICK_W'(1) : sample_delay_r;
      run_nxt  = 1'b1;
      pend_nxt = 1'b1;
    end

    if (cnt_nxt >= trc_pkg::CNT_W'(trc_pkg::FRAME_SAMPLES)) begin
      emit    = 1'b1;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      cd_r    <= '0;
      run_r   <= 1'b0;
    end else if (in_acc) begin
      store_r <= store_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      cd_r    <= cd_nxt;
      run_r   <= run_nxt;
    end
  end

  trc_decode u_decode (
    .samples        (store_nxt),
    .preset_address (preset_address_r),
    .result         (frame_result)
  );

  trc_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && emit),
    .push_data (frame_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_frame_status   = out_data.frame_status;
  assign out_data_digits    = out_data.data_digits;
  assign out_address_digits = out_data.address_digits;

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < trc_pkg::CNT_W'(trc_pkg::FRAME_SAMPLES))
    else $error("sample count reached frame length without a decode");

  a_pend_runs: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> run_r)
    else $error("sample pending with timer stopped");

  a_timer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (cd_r != '0))
    else $error("running timer holds zero");

  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("skid entry held behind an empty output register");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_status == trc_pkg::ST_OK ||
                   out_frame_status == trc_pkg::ST_BAD_PAIR ||
                   out_frame_status == trc_pkg::ST_MISMATCH))
    else $error("illegal frame status on output");
`endif

endmodule

// File: sv/trc_decode.sv
// Frame decoder: turns a full sample store into status and digit fields.
// Depends on trc_pkg.
module trc_decode (
  input  logic [trc_pkg::FRAME_SAMPLES-1:0] samples,
  input  logic [trc_pkg::FIELD_W-1:0]       preset_address,
  output trc_pkg::result_t                  result
);

  logic                         bad;
  logic                         mism;
  logic [trc_pkg::FIELD_W-1:0]  addr;
  logic [trc_pkg::FIELD_W-1:0]  data;
  logic                         a;
  logic                         b;
  logic [trc_pkg::DIGIT_W-1:0]  d;

  always_comb begin
    bad  = 1'b0;
    mism = 1'b0;
    addr = '0;
    data = '0;
    a    = 1'b0;
    b    = 1'b0;
    d    = '0;
    for (int j = 0; j < trc_pkg::DIGITS; j++) begin
      a = samples[2*j];
      b = samples[2*j+1];
      d = {1'b0, a} + {1'b0, b};
      // low then high is not a legal tristate pair
      if (!a && b) bad = 1'b1;
      if (j < trc_pkg::ADDR_DIGITS) begin
        if (d != preset_address[trc_pkg::DIGIT_W*j +: trc_pkg::DIGIT_W]) mism = 1'b1;
        addr[trc_pkg::DIGIT_W*j +: trc_pkg::DIGIT_W] = d;
      end else begin
        data[trc_pkg::DIGIT_W*(j-trc_pkg::ADDR_DIGITS) +: trc_pkg::DIGIT_W] = d;
      end
    end

    if (bad) begin
      result.frame_status   = trc_pkg::ST_BAD_PAIR;
      result.data_digits    = '0;
      result.address_digits = '0;
    end else if (mism) begin
      result.frame_status   = trc_pkg::ST_MISMATCH;
      result.data_digits    = '0;
      result.address_digits = '0;
    end else begin
      result.frame_status   = trc_pkg::ST_OK;
      result.data_digits    = data;
      result.address_digits = addr;
    end
  end

endmodule

// File: sv/trc_out_skid.sv
// Result output register with one skid entry behind it.
// Depends on trc_pkg.
module trc_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  trc_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output trc_pkg::result_t out_data
);

  logic             out_valid_r;
  logic             skid_valid_r;
  trc_pkg::result_t out_data_r;
  trc_pkg::result_t skid_data_r;
  logic             pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // no push can arrive while the skid entry is held
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= push_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// File: tb/sv/tb_tristate_remote_code_receiver.sv
// Self-checking testbench for tristate_remote_code_receiver: line-level beats in, results out.
// Carries its own receiver predictor, a bursty beat driver, a result stall driver, a monitor and a watchdog.
// Depends on trc_pkg and the tristate_remote_code_receiver RTL.
module tb_tristate_remote_code_receiver;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 8;
  localparam int MIN_BEATS    = 1350;

  typedef enum int {FK_GOOD, FK_MISMATCH, FK_BAD_PAIR, FK_BROKEN, FK_NOISE} frame_kind_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_line_level = 1'b1;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    out_frame_status;
  logic [trc_pkg::FIELD_W-1:0]   out_data_digits;
  logic [trc_pkg::FIELD_W-1:0]   out_address_digits;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [trc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [trc_pkg::TICK_W-1:0]    cfg_data = '0;

  tristate_remote_code_receiver i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_line_level     (in_line_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_status  (out_frame_status),
    .out_data_digits   (out_data_digits),
    .out_address_digits(out_address_digits),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  // Line levels waiting to be driven and frame results waiting to arrive
  bit               line_q[$];
  trc_pkg::result_t frame_q[$];

  int n_errors = 0;
  int n_sent = 0;

  // Receiver predictor state
  logic [trc_pkg::FRAME_SAMPLES-1:0] smp_bits;
  int unsigned                       smp_cnt;
  bit                                smp_armed;
  logic [trc_pkg::TICK_W-1:0]        tick_left;
  bit                                tick_on;
  logic [trc_pkg::TICK_W-1:0]        delay_reg;
  logic [trc_pkg::TICK_W-1:0]        timeout_reg;
  logic [trc_pkg::FIELD_W-1:0]       addr_reg;

  // Stimulus-side view of the registers
  int                          gen_delay = 1;
  int                          gen_timeout = 1;
  logic [trc_pkg::FIELD_W-1:0] gen_preset = trc_pkg::PRESET_ADDRESS_RST;

  logic             in_taken = 1'b0;
  int               burst_left = 1;
  int               gap_left = 0;
  int               mode_left = 0;
  int               stall_pct = 0;
  int               hold_left = 0;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;
  int               idle_cycles = 0;
  trc_pkg::result_t want;

  task automatic load_ticks(input logic [trc_pkg::TICK_W-1:0] n);
    tick_left = (n == '0) ? trc_pkg::TICK_W'(1) : n;
    tick_on   = 1'b1;
  endtask

  function automatic trc_pkg::result_t decode_frame_bits(
      input logic [trc_pkg::FRAME_SAMPLES-1:0] s,
      input logic [trc_pkg::FIELD_W-1:0]       preset);
    trc_pkg::result_t r;
    logic             a;
    logic             b;
    logic [1:0]       d;
    bit               ok;
    r  = '0;
    ok = 1'b1;
    for (int j = 0; j < trc_pkg::DIGITS; j++) begin
      a = s[2*j];
      b = s[2*j+1];
      // low-then-high pair kills the frame outright
      if (!a && b) begin
        r = '0;
        r.frame_status = trc_pkg::ST_BAD_PAIR;
        return r;
      end
      d = {1'b0, a} + {1'b0, b};
      if (j < trc_pkg::ADDR_DIGITS) begin
        if (d != preset[2*j +: 2]) ok = 1'b0;
        r.address_digits[2*j +: 2] = d;
      end else begin
        r.data_digits[2*(j-trc_pkg::ADDR_DIGITS) +: 2] = d;
      end
    end
    if (!ok) begin
      r = '0;
      r.frame_status = trc_pkg::ST_MISMATCH;
    end else begin
      r.frame_status = trc_pkg::ST_OK;
    end
    return r;
  endfunction

  task automatic step_receiver(input logic level);
    if (tick_on) begin
      if (tick_left != '0) tick_left--;
      if (tick_left == '0) begin
        if (smp_armed) begin
          smp_armed = 1'b0;
          if (smp_cnt < trc_pkg::FRAME_SAMPLES) begin
            smp_bits[smp_cnt] = level;
            smp_cnt++;
          end
          load_ticks(timeout_reg);
        end else begin
          // no new low in time: drop the partial frame
          smp_cnt = 0;
          tick_on = 1'b0;
        end
      end
    end
    if (!level && !smp_armed) begin
      load_ticks(delay_reg);
      smp_armed = 1'b1;
    end
    if (smp_cnt >= trc_pkg::FRAME_SAMPLES) begin
      frame_q.push_back(decode_frame_bits(smp_bits, addr_reg));
      smp_cnt = 0;
    end
  endtask

  // Predict on every accepted beat and register write
  always @(posedge clk) begin
    if (!rst_n) begin
      smp_bits    = '0;
      smp_cnt     = 0;
      smp_armed   = 1'b0;
      tick_left   = '0;
      tick_on     = 1'b0;
      delay_reg   = trc_pkg::SAMPLE_DELAY_RST;
      timeout_reg = trc_pkg::BIT_TIMEOUT_RST;
      addr_reg    = trc_pkg::PRESET_ADDRESS_RST;
      in_taken   <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          trc_pkg::REG_SAMPLE_DELAY:   delay_reg = cfg_data;
          trc_pkg::REG_BIT_TIMEOUT:    timeout_reg = cfg_data;
          trc_pkg::REG_PRESET_ADDRESS: addr_reg = cfg_data[trc_pkg::FIELD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) step_receiver(in_line_level);
    end
  end

  // Beat driver: bursts of random length, random gaps between them
  always @(negedge clk) begin
    logic nv;
    logic nl;
    nv = in_valid;
    nl = in_line_level;
    if (!in_valid || in_taken) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (line_q.size() > 0) begin
        nv = 1'b1;
        nl = line_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    in_valid      <= nv;
    in_line_level <= nl;
  end

  // Result stall pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 20;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        mode_left = $urandom_range(10, 120);
      end
      mode_left--;
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d data %h address %h",
                 $time, out_frame_status, out_data_digits, out_address_digits);
        n_errors++;
      end else begin
        want = frame_q.pop_front();
        if (out_frame_status !== want.frame_status) begin
          $display("%0t: frame_status expected %0d actual %0d",
                   $time, want.frame_status, out_frame_status);
          n_errors++;
        end
        if (out_data_digits !== want.data_digits) begin
          $display("%0t: data_digits expected %h actual %h",
                   $time, want.data_digits, out_data_digits);
          n_errors++;
        end
        if (out_address_digits !== want.address_digits) begin
          $display("%0t: address_digits expected %h actual %h",
                   $time, want.address_digits, out_address_digits);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [trc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [trc_pkg::TICK_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      trc_pkg::REG_SAMPLE_DELAY:   gen_delay = (val == '0) ? 1 : int'(val);
      trc_pkg::REG_BIT_TIMEOUT:    gen_timeout = (val == '0) ? 1 : int'(val);
      trc_pkg::REG_PRESET_ADDRESS: gen_preset = val[trc_pkg::FIELD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic put_level(input bit level);
    line_q.push_back(level);
    n_sent++;
  endtask

  // Arm with a low, then present each sample at its sample point
  task automatic push_samples(input logic [trc_pkg::FRAME_SAMPLES-1:0] s, input int n);
    put_level(1'b0);
    for (int i = 0; i < n; i++) begin
      repeat (gen_delay - 1) put_level(1'($urandom_range(0, 1)));
      put_level(s[i]);
      // a low sample re-arms by itself, a high one needs a fresh low
      if (s[i] && i < n - 1) put_level(1'b0);
    end
  endtask

  // Hold the line high long enough for a partial frame to time out, if the bit timeout is at most 40
  task automatic push_gap();
    repeat (gen_delay + ((gen_timeout > 40) ? 40 : gen_timeout) + 2 + $urandom_range(0, 3))
      put_level(1'b1);
  endtask

  function automatic logic [trc_pkg::FRAME_SAMPLES-1:0] make_frame(input frame_kind_t k);
    logic [trc_pkg::FRAME_SAMPLES-1:0] s;
    logic [1:0]                        d;
    int                                flip_j;
    int                                bad_j;
    s      = '0;
    flip_j = $urandom_range(0, trc_pkg::ADDR_DIGITS - 1);
    bad_j  = $urandom_range(0, trc_pkg::DIGITS - 1);
    for (int j = 0; j < trc_pkg::DIGITS; j++) begin
      if (j < trc_pkg::ADDR_DIGITS) begin
        d = gen_preset[2*j +: 2];
        if (k == FK_MISMATCH && j == flip_j) d = 2'((d + 1 + $urandom_range(0, 1)) % 3);
      end else begin
        d = 2'($urandom_range(0, 2));
      end
      s[2*j]   = (d != 2'd0);
      s[2*j+1] = (d == 2'd2);
      if (k == FK_BAD_PAIR && j == bad_j) begin
        s[2*j]   = 1'b0;
        s[2*j+1] = 1'b1;
      end
    end
    s[trc_pkg::FRAME_SAMPLES-1] = 1'($urandom_range(0, 1));
    return s;
  endfunction

  task automatic push_frame(input frame_kind_t k);
    case (k)
      FK_BROKEN: push_samples(make_frame(FK_GOOD), $urandom_range(1, trc_pkg::FRAME_SAMPLES - 1));
      FK_NOISE:  repeat ($urandom_range(5, 60)) put_level(1'($urandom_range(0, 1)));
      default:   push_samples(make_frame(k), trc_pkg::FRAME_SAMPLES);
    endcase
    push_gap();
  endtask

  task automatic run_frames(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62)      push_frame(FK_GOOD);
      else if (pick < 72) push_frame(FK_MISMATCH);
      else if (pick < 82) push_frame(FK_BAD_PAIR);
      else if (pick < 91) push_frame(FK_BROKEN);
      else                push_frame(FK_NOISE);
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (line_q.size() != 0 || in_valid || frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [trc_pkg::FIELD_W-1:0] p;
    int                          n_phase;
    n_phase = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero delay, all-high address, every status, a timed-out frame
    write_reg(trc_pkg::REG_SAMPLE_DELAY, '0);
    write_reg(trc_pkg::REG_BIT_TIMEOUT, trc_pkg::TICK_W'(3));
    write_reg(trc_pkg::REG_PRESET_ADDRESS, trc_pkg::TICK_W'(2730));
    push_frame(FK_GOOD);
    push_frame(FK_BAD_PAIR);
    push_frame(FK_MISMATCH);
    push_frame(FK_BROKEN);
    push_frame(FK_GOOD);
    wait_idle();

    // All-low address, longest timeout
    write_reg(trc_pkg::REG_PRESET_ADDRESS, '0);
    write_reg(trc_pkg::REG_BIT_TIMEOUT, '1);
    write_reg(trc_pkg::REG_SAMPLE_DELAY, trc_pkg::TICK_W'(2));
    push_frame(FK_GOOD);
    push_frame(FK_GOOD);
    wait_idle();

    // Zero timeout acts as one tick: high samples break the frame
    write_reg(trc_pkg::REG_BIT_TIMEOUT, '0);
    write_reg(trc_pkg::REG_SAMPLE_DELAY, trc_pkg::TICK_W'(1));
    push_frame(FK_GOOD);
    push_frame(FK_NOISE);
    wait_idle();

    // Random phases of well-formed frames with some broken ones and noise
    while (n_sent < MIN_BEATS || n_phase < 2) begin
      for (int j = 0; j < trc_pkg::ADDR_DIGITS; j++) p[2*j +: 2] = 2'($urandom_range(0, 2));
      if (n_phase == 1 || $urandom_range(0, 3) != 0)
        write_reg(trc_pkg::REG_SAMPLE_DELAY,
                  (n_phase == 1) ? trc_pkg::TICK_W'(1) : trc_pkg::TICK_W'($urandom_range(1, 3)));
      if ($urandom_range(0, 3) != 0)
        write_reg(trc_pkg::REG_BIT_TIMEOUT, trc_pkg::TICK_W'($urandom_range(2, 10)));
      if ($urandom_range(0, 3) != 0)
        write_reg(trc_pkg::REG_PRESET_ADDRESS, trc_pkg::TICK_W'(p));
      // fill the result slots while out_stall holds off the result side
      if (n_phase == 1) hold_req = 1'b1;
      run_frames((n_phase == 1) ? 12 : $urandom_range(4, 8));
      wait_idle();
      n_phase++;
    end

    // Longest delay: nothing completes, the arming path still runs
    write_reg(trc_pkg::REG_BIT_TIMEOUT, '1);
    write_reg(trc_pkg::REG_SAMPLE_DELAY, '1);
    repeat (60) put_level(1'($urandom_range(0, 1)));
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
